>>> rtl/pidc_pkg.sv
// Shared constants for the positional/incremental PID controller.
package pidc_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int IO_WIDTH       = 32;
    localparam int CFG_IDX_WIDTH  = 3;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_P    = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_I    = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_D    = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OUT_LIM   = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_INT_LIM   = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEAD_BAND = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_VI_BOUNDS = 3'd7;

    localparam int MODE_INCR  = 0;
    localparam int MODE_VARI  = 1;
    localparam int MODE_DMEAS = 2;

endpackage

>>> rtl/pid_controller_pos_inc_unit.sv
// PID controller (positional or incremental) built around one shared multiplier.
// A transaction runs from acceptance to drive_out; a zero I or D gain skips that term's steps,
// the variable-speed integral adds a divide, and a dead band hit goes straight to the output.
// A new transaction is accepted only once the sequencer has returned to idle; each product
// is formed on the single W x 16 multiplier, upper gain half first, and a held result waits.
// Reset is asynchronous and active low and clears histories, integral, registers and sequencer.
module pid_controller_pos_inc_unit #(
    parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [pidc_pkg::IO_WIDTH-1:0] measured,
    input  logic signed [pidc_pkg::IO_WIDTH-1:0] setpoint,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pidc_pkg::IO_WIDTH-1:0] drive_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [31:0]                          cfg_data
);
    import pidc_pkg::*;

    // Working width and the wider width used for sums before saturation.
    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int EW  = ((W > IO_WIDTH) ? W : IO_WIDTH) + 3;
    localparam int VW  = ((W > F + 8) ? W : F + 8) + 2;
    localparam int PW  = W + 32;
    localparam int QW  = PW + 1 - F;
    localparam int DCW = $clog2(F + 1);

    localparam logic signed [EW-1:0] VMAX_E = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] VMIN_E = ~VMAX_E;
    localparam logic signed [W-1:0]  VMAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  VMIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic [QW-1:0]        VMAX_Q = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [PW:0]          HALF_P = {{(PW+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    // Low-pass coefficient, 0.05 rounded to the fraction grid.
    localparam logic [31:0]          LP_K   = 32'((((64'd1 << F) * 5) + 50) / 100);

    // Sequencer states.
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ERR  = 5'd1;
    localparam logic [4:0] S_LPE  = 5'd2;
    localparam logic [4:0] S_LPE2 = 5'd3;
    localparam logic [4:0] S_P    = 5'd4;
    localparam logic [4:0] S_P2   = 5'd5;
    localparam logic [4:0] S_I2   = 5'd6;
    localparam logic [4:0] S_DIV  = 5'd7;
    localparam logic [4:0] S_I3   = 5'd8;
    localparam logic [4:0] S_I3R  = 5'd9;
    localparam logic [4:0] S_I4   = 5'd10;
    localparam logic [4:0] S_I5   = 5'd11;
    localparam logic [4:0] S_D    = 5'd12;
    localparam logic [4:0] S_D3   = 5'd13;
    localparam logic [4:0] S_D4   = 5'd14;
    localparam logic [4:0] S_D5   = 5'd15;
    localparam logic [4:0] S_D6   = 5'd16;
    localparam logic [4:0] S_FIN  = 5'd17;
    localparam logic [4:0] S_MUL  = 5'd18;
    localparam logic [4:0] S_MULR = 5'd19;

    function automatic logic signed [EW-1:0] ext(input logic signed [W-1:0] v);
        ext = {{(EW-W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [EW-1:0] zext31(input logic [30:0] v);
        zext31 = $signed({{(EW-31){1'b0}}, v});
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [EW-1:0] x);
        if (x > VMAX_E)
            sat_w = VMAX_W;
        else if (x < VMIN_E)
            sat_w = VMIN_W;
        else
            sat_w = x[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] clamp_w(input logic signed [W-1:0] x,
                                                    input logic [30:0] lim);
        logic signed [EW-1:0] xe;
        logic signed [EW-1:0] le;
        logic signed [EW-1:0] ne;
        xe = ext(x);
        le = zext31(lim);
        ne = -le;
        if (xe > le)
            clamp_w = le[W-1:0];
        else if (xe < ne)
            clamp_w = ne[W-1:0];
        else
            clamp_w = x;
    endfunction

    // Registers.
    logic [4:0]          state_reg, state_next, ret_reg, ret_next;
    logic signed [W-1:0] meas_reg, meas_next, setp_reg, setp_next;
    logic signed [W-1:0] eh0_reg, eh0_next, eh1_reg, eh1_next, eh2_reg, eh2_next;
    logic signed [W-1:0] dh0_reg, dh0_next, dh1_reg, dh1_next;
    logic signed [W-1:0] mh0_reg, mh0_next, mh1_reg, mh1_next, mh2_reg, mh2_next;
    logic signed [W-1:0] iacc_reg, iacc_next, sum_reg, sum_next;
    logic signed [W-1:0] tmp_reg, tmp_next, prod_reg, prod_next;
    logic [31:0]         mul_g_reg, mul_g_next;
    logic [W-1:0]        mul_m_reg, mul_m_next;
    logic                mul_neg_reg, mul_neg_next, mul_cnt_reg, mul_cnt_next;
    logic [PW-1:0]       acc_reg, acc_next;
    logic [F+7:0]        div_rem_reg, div_rem_next, div_a_reg, div_a_next;
    logic [F-1:0]        div_q_reg, div_q_next;
    logic [DCW-1:0]      div_cnt_reg, div_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [IO_WIDTH-1:0] drive_out_reg, drive_out_next;

    logic [2:0]  mode_reg;
    logic [30:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [30:0] out_lim_reg, int_lim_reg, dead_band_reg;
    logic [31:0] vi_bounds_reg;

    // Call interface into the shared multiplier.
    logic                call_en;
    logic [31:0]         call_g;
    logic signed [W-1:0] call_v;
    logic [4:0]          call_ret;

    logic incr;
    assign incr = mode_reg[MODE_INCR];

    // Configuration writes must only be issued while the block is idle; the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            out_lim_reg   <= '0;
            int_lim_reg   <= '0;
            dead_band_reg <= '0;
            vi_bounds_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[2:0];
                REG_GAIN_P:    gain_p_reg    <= cfg_data[30:0];
                REG_GAIN_I:    gain_i_reg    <= cfg_data[30:0];
                REG_GAIN_D:    gain_d_reg    <= cfg_data[30:0];
                REG_OUT_LIM:   out_lim_reg   <= cfg_data[30:0];
                REG_INT_LIM:   int_lim_reg   <= cfg_data[30:0];
                REG_DEAD_BAND: dead_band_reg <= cfg_data[30:0];
                REG_VI_BOUNDS: vi_bounds_reg <= cfg_data;
                default:       mode_reg      <= mode_reg;
            endcase
        end
    end

    // Combinational helpers for the individual sequencer steps.
    logic signed [W-1:0]  err_new;
    logic signed [EW-1:0] err_abs;
    logic signed [VW-1:0] vi_ae, vi_a, vi_b;
    logic [W+15:0]        mul_part;
    logic [PW:0]          mul_round;
    logic [QW-1:0]        mul_q;
    logic [W-1:0]         mul_qw;
    logic [F+8:0]         div_shift;
    logic signed [W-1:0]  res_w;
    logic signed [EW-1:0] res_e;

    always_comb
    begin
        err_new = sat_w(ext(setp_reg) - ext(meas_reg));
        err_abs = err_new[W-1] ? -ext(err_new) : ext(err_new);

        vi_ae = eh0_reg[W-1] ? -$signed({{(VW-W){eh0_reg[W-1]}}, eh0_reg})
                             :  $signed({{(VW-W){1'b0}}, eh0_reg});
        vi_b  = $signed({{(VW-16){1'b0}}, vi_bounds_reg[15:0]}) <<< (F - 8);
        vi_a  = $signed({{(VW-16){1'b0}}, vi_bounds_reg[31:16]}) <<< (F - 8);

        mul_part  = mul_m_reg * (mul_cnt_reg ? mul_g_reg[15:0] : mul_g_reg[31:16]);
        mul_round = {1'b0, acc_reg} + HALF_P;
        mul_q     = mul_round[PW:F];
        mul_qw    = mul_q[W-1:0];

        div_shift = {div_rem_reg, 1'b0};

        res_w = clamp_w(sum_reg, out_lim_reg);
        res_e = ext(res_w);
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        meas_next      = meas_reg;
        setp_next      = setp_reg;
        eh0_next       = eh0_reg;
        eh1_next       = eh1_reg;
        eh2_next       = eh2_reg;
        dh0_next       = dh0_reg;
        dh1_next       = dh1_reg;
        mh0_next       = mh0_reg;
        mh1_next       = mh1_reg;
        mh2_next       = mh2_reg;
        iacc_next      = iacc_reg;
        sum_next       = sum_reg;
        tmp_next       = tmp_reg;
        prod_next      = prod_reg;
        mul_g_next     = mul_g_reg;
        mul_m_next     = mul_m_reg;
        mul_neg_next   = mul_neg_reg;
        mul_cnt_next   = mul_cnt_reg;
        acc_next       = acc_reg;
        div_rem_next   = div_rem_reg;
        div_a_next     = div_a_reg;
        div_q_next     = div_q_reg;
        div_cnt_next   = div_cnt_reg;
        drive_out_next = drive_out_reg;
        out_valid_next = out_valid_reg && out_stall;
        call_en        = 1'b0;
        call_g         = '0;
        call_v         = '0;
        call_ret       = S_IDLE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    meas_next  = sat_w($signed({{(EW-IO_WIDTH){measured[IO_WIDTH-1]}},
                                                measured}));
                    setp_next  = sat_w($signed({{(EW-IO_WIDTH){setpoint[IO_WIDTH-1]}},
                                                setpoint}));
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                eh2_next = eh1_reg;
                eh1_next = eh0_reg;
                eh0_next = err_new;
                if (err_abs < zext31(dead_band_reg))
                begin
                    sum_next   = '0;
                    state_next = S_FIN;
                end
                else
                    state_next = S_LPE;
            end
            S_LPE:
            begin
                call_en  = 1'b1;
                call_g   = LP_K;
                call_v   = sat_w(ext(eh0_reg) - ext(eh1_reg));
                call_ret = S_LPE2;
            end
            S_LPE2:
            begin
                eh0_next   = sat_w(ext(eh0_reg) - ext(prod_reg));
                state_next = S_P;
            end
            S_P:
            begin
                call_en  = 1'b1;
                call_g   = {1'b0, gain_p_reg};
                call_v   = incr ? sat_w(ext(eh0_reg) - ext(eh1_reg)) : eh0_reg;
                call_ret = S_P2;
            end
            S_P2:
            begin
                sum_next = prod_reg;
                if (gain_i_reg != '0)
                begin
                    call_en  = 1'b1;
                    call_g   = {1'b0, gain_i_reg};
                    call_v   = eh0_reg;
                    call_ret = S_I2;
                end
                else
                begin
                    if (!incr)
                        iacc_next = '0;
                    state_next = S_D;
                end
            end
            S_I2:
            begin
                tmp_next   = prod_reg;
                state_next = S_I4;
                if (mode_reg[MODE_VARI] && (vi_ae > vi_b))
                begin
                    if (vi_ae <= vi_a + vi_b)
                    begin
                        div_rem_next = (F+8)'(vi_a + vi_b - vi_ae);
                        div_a_next   = (F+8)'(vi_a);
                        div_q_next   = '0;
                        div_cnt_next = DCW'(F);
                        state_next   = S_DIV;
                    end
                    else
                        tmp_next = '0;
                end
            end
            S_DIV:
            begin
                // One quotient bit per cycle; the remainder stays below the divisor.
                if (div_cnt_reg == '0)
                    state_next = S_I3;
                else
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                    if (div_shift >= {1'b0, div_a_reg})
                    begin
                        div_rem_next = (F+8)'(div_shift - {1'b0, div_a_reg});
                        div_q_next   = {div_q_reg[F-2:0], 1'b1};
                    end
                    else
                    begin
                        div_rem_next = div_shift[F+7:0];
                        div_q_next   = {div_q_reg[F-2:0], 1'b0};
                    end
                end
            end
            S_I3:
            begin
                call_en  = 1'b1;
                call_g   = 32'(div_q_reg);
                call_v   = tmp_reg;
                call_ret = S_I3R;
            end
            S_I3R:
            begin
                tmp_next   = prod_reg;
                state_next = S_I4;
            end
            S_I4:
            begin
                if (incr)
                    iacc_next = clamp_w(tmp_reg, int_lim_reg);
                else
                    iacc_next = clamp_w(sat_w(ext(iacc_reg) + ext(tmp_reg)), int_lim_reg);
                state_next = S_I5;
            end
            S_I5:
            begin
                sum_next   = sat_w(ext(sum_reg) + ext(iacc_reg));
                state_next = S_D;
            end
            S_D:
            begin
                if (gain_d_reg == '0)
                    state_next = S_FIN;
                else
                begin
                    if (mode_reg[MODE_DMEAS])
                    begin
                        mh2_next = mh1_reg;
                        mh1_next = mh0_reg;
                        mh0_next = meas_reg;
                        if (incr)
                            tmp_next = sat_w(-(ext(meas_reg) - (ext(mh0_reg) <<< 1)
                                               + ext(mh1_reg)));
                        else
                            tmp_next = sat_w(ext(mh0_reg) - ext(meas_reg));
                    end
                    else
                    begin
                        if (incr)
                            tmp_next = sat_w(ext(eh0_reg) - (ext(eh1_reg) <<< 1)
                                             + ext(eh2_reg));
                        else
                            tmp_next = sat_w(ext(eh0_reg) - ext(eh1_reg));
                    end
                    dh1_next   = dh0_reg;
                    state_next = S_D3;
                end
            end
            S_D3:
            begin
                call_en  = 1'b1;
                call_g   = LP_K;
                call_v   = sat_w(ext(tmp_reg) - ext(dh1_reg));
                call_ret = S_D4;
            end
            S_D4:
            begin
                dh0_next   = sat_w(ext(tmp_reg) - ext(prod_reg));
                state_next = S_D5;
            end
            S_D5:
            begin
                call_en  = 1'b1;
                call_g   = {1'b0, gain_d_reg};
                call_v   = dh0_reg;
                call_ret = S_D6;
            end
            S_D6:
            begin
                sum_next   = sat_w(ext(sum_reg) + ext(prod_reg));
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    drive_out_next = res_e[IO_WIDTH-1:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MUL:
            begin
                // Upper 16 bits of the gain first, then the lower 16 bits.
                acc_next     = (acc_reg << 16) + PW'(mul_part);
                mul_cnt_next = 1'b1;
                if (mul_cnt_reg)
                    state_next = S_MULR;
            end
            S_MULR:
            begin
                if (mul_q > VMAX_Q)
                    prod_next = mul_neg_reg ? VMIN_W : VMAX_W;
                else
                    prod_next = mul_neg_reg ? -$signed(mul_qw) : $signed(mul_qw);
                state_next = ret_reg;
            end
            default:
                state_next = S_IDLE;
        endcase

        if (call_en)
        begin
            mul_g_next   = call_g;
            mul_neg_next = call_v[W-1];
            mul_m_next   = call_v[W-1] ? W'(-call_v) : call_v;
            mul_cnt_next = 1'b0;
            acc_next     = '0;
            ret_next     = call_ret;
            state_next   = S_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
            eh0_reg       <= '0;
            eh1_reg       <= '0;
            eh2_reg       <= '0;
            dh0_reg       <= '0;
            dh1_reg       <= '0;
            mh0_reg       <= '0;
            mh1_reg       <= '0;
            mh2_reg       <= '0;
            iacc_reg      <= '0;
            drive_out_reg <= '0;
            div_cnt_reg   <= '0;
            mul_cnt_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            eh0_reg       <= eh0_next;
            eh1_reg       <= eh1_next;
            eh2_reg       <= eh2_next;
            dh0_reg       <= dh0_next;
            dh1_reg       <= dh1_next;
            mh0_reg       <= mh0_next;
            mh1_reg       <= mh1_next;
            mh2_reg       <= mh2_next;
            iacc_reg      <= iacc_next;
            drive_out_reg <= drive_out_next;
            div_cnt_reg   <= div_cnt_next;
            mul_cnt_reg   <= mul_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg    <= meas_next;
        setp_reg    <= setp_next;
        sum_reg     <= sum_next;
        tmp_reg     <= tmp_next;
        prod_reg    <= prod_next;
        mul_g_reg   <= mul_g_next;
        mul_m_reg   <= mul_m_next;
        mul_neg_reg <= mul_neg_next;
        acc_reg     <= acc_next;
        div_rem_reg <= div_rem_next;
        div_a_reg   <= div_a_next;
        div_q_reg   <= div_q_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign drive_out = drive_out_reg;

`ifndef SYNTHESIS
    logic signed [EW-1:0] chk_iacc, chk_ilim;
    assign chk_iacc = ext(iacc_reg);
    assign chk_ilim = zext31(int_lim_reg);

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_ERR)
        else $error("accepted transaction did not start the sequencer");

    a_integral_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_I5 |-> (chk_iacc <= chk_ilim) && (chk_iacc >= -chk_ilim))
        else $error("integral term outside its limit");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_rem_reg < div_a_reg)
        else $error("divider remainder not below divisor");
`endif

endmodule
